FILE: hw/rtl/hmq_pkg.sv
// hmq_pkg: shared types and constants for the binary max-heap queue unit
// no dependencies; used by the top level, the compare unit and the checker

package hmq_pkg;

    // fixed port widths of the item fields
    localparam int unsigned PORT_VAL_W = 32;
    localparam int unsigned PORT_CNT_W = 7;
    localparam int unsigned STATUS_W   = 2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL_DROP = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY_POP = 2'd2;

    // request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // decisions of the shared compare unit
    typedef struct packed {
        logic up_move;    // parent smaller than the held value
        logic dn_take_l;  // left child wins over the held value
        logic dn_take_r;  // right child wins over the current best
    } t_cmp_res;

endpackage

FILE: hw/rtl/hmq_ram.sv
// hmq_ram: heap store, one write port and two registered read ports
// no package dependency

module hmq_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

FILE: hw/rtl/hmq_cmp_unit.sv
// hmq_cmp_unit: shared unsigned comparator for sift-up and sift-down steps
// depends on hmq_pkg (t_cmp_res)

module hmq_cmp_unit #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic [VALUE_WIDTH-1:0] i_hold,
    input  logic [VALUE_WIDTH-1:0] i_rd_a,
    input  logic [VALUE_WIDTH-1:0] i_rd_b,
    input  logic                   i_r_ok,
    output hmq_pkg::t_cmp_res      o_res
);

    logic [VALUE_WIDTH-1:0] best_val;

    always_comb begin
        // sift-up: port a carries the parent
        o_res.up_move   = (i_rd_a < i_hold);
        // sift-down: port a left child, port b right child; left wins a tie
        o_res.dn_take_l = (i_hold < i_rd_a);
        best_val        = o_res.dn_take_l ? i_rd_a : i_hold;
        o_res.dn_take_r = i_r_ok && (best_val < i_rd_b);
    end

endmodule

FILE: hw/rtl/binary_max_heap_queue_unit.sv
// binary_max_heap_queue_unit: max-priority queue kept as an array binary heap
// depends on hmq_pkg, hmq_ram and hmq_cmp_unit

// Each item is a push or a pop and returns exactly one result item: the largest
// stored value (zero when empty), an empty flag, the entry count and a status
// (done, push dropped because full, pop on empty ignored). Values are compared
// unsigned and ties never swap; going down the left child wins a tie. One item
// is worked on at a time and the input stalls meanwhile. A push or pop walks at
// most log2(CAPACITY) heap levels, six for 64 entries; a pop first reads the
// last entry into the hole. Every level is a read of the parent or both
// children through the store's registered read ports, then a compare in the
// shared comparator that moves one entry. A dropped push or ignored pop goes
// straight to reading the root. The finished result sits in an output
// register, so the next item is taken while it waits to be collected; the
// store itself needs no clearing, since only slots below the count are read.

module binary_max_heap_queue_unit #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [hmq_pkg::PORT_VAL_W-1:0]    i_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hmq_pkg::PORT_VAL_W-1:0]    o_top_value,
    output logic                              o_is_empty,
    output logic [hmq_pkg::PORT_CNT_W-1:0]    o_entry_count,
    output logic [hmq_pkg::STATUS_W-1:0]      o_status
);

    localparam int unsigned AW = $clog2(CAPACITY);      // slot index width
    localparam int unsigned CW = $clog2(CAPACITY + 1);  // count width
    localparam int unsigned XW = AW + 2;                // child index width

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_POP_RD = 4'd3;
    localparam logic [3:0] S_POP_LD = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_CMP = 4'd6;
    localparam logic [3:0] S_TOP_RD = 4'd7;
    localparam logic [3:0] S_TOP_LD = 4'd8;

    // control state
    logic [3:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    // working payload
    logic [AW-1:0]          r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_hold, n_hold;
    logic [hmq_pkg::STATUS_W-1:0] r_stat, n_stat;
    // output register
    logic [hmq_pkg::PORT_VAL_W-1:0] r_out_top, n_out_top;
    logic                   r_out_empty, n_out_empty;
    logic [hmq_pkg::PORT_CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic [hmq_pkg::STATUS_W-1:0]   r_out_stat, n_out_stat;

    // store ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr_a;
    logic [AW-1:0]          ram_raddr_b;
    logic [VALUE_WIDTH-1:0] ram_rdata_a;
    logic [VALUE_WIDTH-1:0] ram_rdata_b;

    // heap index arithmetic
    logic [XW-1:0]          pos_x;
    logic [XW-1:0]          left_x;
    logic [XW-1:0]          right_x;
    logic [XW-1:0]          count_x;
    logic                   left_ok;
    logic                   right_ok;
    logic [AW-1:0]          parent;
    logic                   is_full;
    logic                   in_accept;
    logic                   out_free;

    hmq_pkg::t_cmp_res      cmp_res;

    assign pos_x    = XW'(r_pos);
    assign left_x   = (pos_x << 1) + XW'(1);
    assign right_x  = (pos_x << 1) + XW'(2);
    assign count_x  = XW'(r_count);
    assign left_ok  = (left_x < count_x);
    assign right_ok = (right_x < count_x);
    assign parent   = AW'((r_pos - AW'(1)) >> 1);
    assign is_full  = (r_count == CW'(CAPACITY));

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    // output register may be loaded when empty or being emptied this cycle
    assign out_free   = !r_out_valid || !i_out_stall;

    hmq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_hmq_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    hmq_cmp_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_hmq_cmp_unit (
        .i_hold (r_hold),
        .i_rd_a (ram_rdata_a),
        .i_rd_b (ram_rdata_b),
        .i_r_ok (right_ok),
        .o_res  (cmp_res)
    );

    // sequencer: the held value travels as a hole, entries move one level a step
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_hold      = r_hold;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_top   = r_out_top;
        n_out_empty = r_out_empty;
        n_out_cnt   = r_out_cnt;
        n_out_stat  = r_out_stat;

        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_hold;
        ram_raddr_a = '0;
        ram_raddr_b = right_x[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_stat = hmq_pkg::STAT_DONE;
                    if (i_req_type == hmq_pkg::REQ_PUSH) begin
                        if (is_full) begin
                            n_stat  = hmq_pkg::STAT_FULL_DROP;
                            n_state = S_TOP_RD;
                        end else begin
                            n_hold  = VALUE_WIDTH'(i_value);
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_stat  = hmq_pkg::STAT_EMPTY_POP;
                            n_state = S_TOP_RD;
                        end else begin
                            n_count = r_count - CW'(1);
                            // a single entry leaves nothing to reorder
                            n_state = (r_count == CW'(1)) ? S_TOP_RD : S_POP_RD;
                        end
                    end
                end
            end

            S_UP_RD: begin
                ram_raddr_a = parent;
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_res.up_move) begin
                    // parent drops into the hole, hole moves up
                    ram_wdata = ram_rdata_a;
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_TOP_RD;
                end
            end

            S_POP_RD: begin
                // count already shrunk, so it addresses the last entry
                ram_raddr_a = r_count[AW-1:0];
                n_state     = S_POP_LD;
            end

            S_POP_LD: begin
                n_hold  = ram_rdata_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end

            S_DN_RD: begin
                ram_raddr_a = left_x[AW-1:0];
                if (!left_ok) begin
                    ram_we  = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    n_state = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                ram_we = 1'b1;
                priority if (cmp_res.dn_take_r) begin
                    ram_wdata = ram_rdata_b;
                    n_pos     = right_x[AW-1:0];
                    n_state   = S_DN_RD;
                end else if (cmp_res.dn_take_l) begin
                    ram_wdata = ram_rdata_a;
                    n_pos     = left_x[AW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_TOP_RD;
                end
            end

            S_TOP_RD: begin
                n_state = S_TOP_LD;
            end

            S_TOP_LD: begin
                // address stays on the root, so the read data holds while waiting
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_top   = (r_count == '0) ? '0
                                                  : hmq_pkg::PORT_VAL_W'(ram_rdata_a);
                    n_out_empty = (r_count == '0);
                    n_out_cnt   = hmq_pkg::PORT_CNT_W'(r_count);
                    n_out_stat  = r_stat;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_hold      <= n_hold;
        r_stat      <= n_stat;
        r_out_top   <= n_out_top;
        r_out_empty <= n_out_empty;
        r_out_cnt   <= n_out_cnt;
        r_out_stat  <= n_out_stat;
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_is_empty    = r_out_empty;
    assign o_entry_count = r_out_cnt;
    assign o_status      = r_out_stat;

endmodule

FILE: hw/rtl/hmq_checker.sv
// hmq_checker: port-level checks on the heap queue's result items, plus bind
// depends on hmq_pkg; binds to binary_max_heap_queue_unit

module hmq_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [hmq_pkg::PORT_VAL_W-1:0] o_top_value,
    input logic                           o_is_empty,
    input logic [hmq_pkg::PORT_CNT_W-1:0] o_entry_count,
    input logic [hmq_pkg::STATUS_W-1:0]   o_status
);

    localparam logic [hmq_pkg::PORT_CNT_W-1:0] FULL_CNT = hmq_pkg::PORT_CNT_W'(CAPACITY);

    // a waiting result item holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_top_value)
            && $stable(o_is_empty) && $stable(o_entry_count) && $stable(o_status))
        else $error("result item changed while stalled");

    // empty flag agrees with the count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag and entry count disagree");

    // an empty queue reports a zero maximum
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_top_value == '0))
        else $error("non-zero maximum on empty queue");

    // a dropped push only happens at capacity
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == hmq_pkg::STAT_FULL_DROP) |-> (o_entry_count == FULL_CNT))
        else $error("push dropped below capacity");

    // an ignored pop only happens when empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == hmq_pkg::STAT_EMPTY_POP) |-> o_is_empty)
        else $error("pop ignored on non-empty queue");

endmodule

bind binary_max_heap_queue_unit hmq_checker #(
    .CAPACITY (CAPACITY)
) u_hmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_top_value   (o_top_value),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);
